FILE: design/ptdr_pkg.sv
`timescale 1ns / 1ps
package ptdr_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int IMAGE_SIZE   = 400;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_W        = 17 + FRAC_BITS + 1;
    localparam int STEP_W       = FRAC_BITS + 2;
    localparam int QUO_W        = FRAC_BITS + 1;
    localparam int QCNT_W       = $clog2(QUO_W);
    localparam int POS_W        = 9;
    localparam int COORD_W      = 16;
    localparam int WIDE_W       = 28;
    localparam int Q14_W        = 14;
    localparam int PIVOT_X      = 200;
    localparam int PIVOT_Y_SCL  = 185;
    localparam int PIVOT_Y_ROT  = 200;
    localparam int NUM_REGS     = 6;

    // input codes
    localparam logic [2:0] FUNC_VERTEX    = 3'd0;
    localparam logic [2:0] FUNC_CLOSE     = 3'd1;
    localparam logic [2:0] FUNC_TRANSLATE = 3'd2;
    localparam logic [2:0] FUNC_SCALE     = 3'd3;
    localparam logic [2:0] FUNC_ROTATE    = 3'd4;
    localparam logic [2:0] FUNC_TICK      = 3'd5;

    // register indexes
    localparam logic [2:0] REG_SHIFT_X = 3'd0;
    localparam logic [2:0] REG_SHIFT_Y = 3'd1;
    localparam logic [2:0] REG_SCALE_X = 3'd2;
    localparam logic [2:0] REG_SCALE_Y = 3'd3;
    localparam logic [2:0] REG_COS     = 3'd4;
    localparam logic [2:0] REG_SIN     = 3'd5;

    typedef enum logic [1:0] {
        MODE_LIVE, MODE_TRANSLATE, MODE_SCALE, MODE_ROTATE
    } mode_t;

    typedef enum logic [2:0] {
        KIND_NONE, KIND_VERTEX, KIND_CLOSE, KIND_REDRAW, KIND_TICK
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        mode_t              mode;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
    } item_t;

    typedef struct packed {
        logic signed [9:0]  shift_x;
        logic signed [9:0]  shift_y;
        logic signed [7:0]  scale_x;
        logic signed [7:0]  scale_y;
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
    } cfg_t;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > WIDE_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -WIDE_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/ptdr_front.sv
`timescale 1ns / 1ps
module ptdr_front import ptdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_func,
    input  logic [POS_W-1:0] s_pos_x,
    input  logic [POS_W-1:0] s_pos_y,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      cls;
    logic       push;

    // classify the incoming code
    always_comb begin
        cls.pos_x = s_pos_x;
        cls.pos_y = s_pos_y;
        cls.mode  = MODE_LIVE;
        unique case (s_func)
            FUNC_VERTEX:    cls.kind = KIND_VERTEX;
            FUNC_CLOSE:     cls.kind = KIND_CLOSE;
            FUNC_TRANSLATE: begin cls.kind = KIND_REDRAW; cls.mode = MODE_TRANSLATE; end
            FUNC_SCALE:     begin cls.kind = KIND_REDRAW; cls.mode = MODE_SCALE; end
            FUNC_ROTATE:    begin cls.kind = KIND_REDRAW; cls.mode = MODE_ROTATE; end
            FUNC_TICK:      cls.kind = KIND_TICK;
            default:        cls.kind = KIND_NONE;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: design/ptdr_back.sv
`timescale 1ns / 1ps
module ptdr_back import ptdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic signed [COORD_W-1:0] m_pix_x,
    output logic signed [COORD_W-1:0] m_pix_y,
    output logic        m_in_image,
    output logic        m_clear_first,
    output logic        m_last,
    output logic        m_dropped
);

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_CAPB, S_XM, S_XS, S_DIFF, S_DIV, S_EMIT
    } state_t;

    state_t state_reg;

    logic [2*POS_W-1:0] mem [MAX_VERTICES];
    logic [2*POS_W-1:0] rd_data_reg;
    logic [VIDX_W-1:0]  rd_addr;
    logic [2*POS_W-1:0] va_reg, vb_reg;
    logic [POS_W-1:0]   first_x_reg, first_y_reg;

    logic [VCNT_W-1:0]  vcnt_reg;
    logic [VCNT_W-1:0]  edge_reg;
    logic               open_reg;
    mode_t              mode_reg;
    logic               pend_clr_reg;
    logic               dropped_reg;

    logic               sel_reg;
    logic signed [26:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [18:0] p_sx_reg, p_sy_reg;
    logic signed [COORD_W-1:0] ta_x_reg, ta_y_reg, tb_x_reg, tb_y_reg;

    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    logic signed [STEP_W-1:0] step_x_reg, step_y_reg;
    logic [16:0]        left_reg;
    logic [15:0]        span_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [17:0]        rx_reg, ry_reg;
    logic [QUO_W-1:0]   qx_reg, qy_reg;
    logic [QCNT_W-1:0]  qcnt_reg;

    logic               more_edges;
    logic               out_free;

    // transform datapath
    logic [2*POS_W-1:0]  vsel;
    logic signed [10:0]  cx, cy, cyr;
    logic signed [WIDE_W-1:0] rot_x, rot_y, tx_w, ty_w;
    logic signed [COORD_W-1:0] tx, ty;

    // line setup
    logic signed [COORD_W-1:0] sx0, sy0, sx1, sy1;
    logic signed [16:0]  dx, dy;
    logic [15:0]         mx, my, span;

    // pixel
    logic signed [ACC_W-1:0] ax_adj, ay_adj, px_w, py_w;
    logic signed [COORD_W-1:0] px, py;
    logic                in_img;

    assign more_edges = (edge_reg + VCNT_W'(1)) < vcnt_reg;
    assign out_free   = !m_tvalid || m_tready;
    assign q_pop      = (state_reg == S_IDLE) && q_valid;

    always_comb begin
        rd_addr = edge_reg[VIDX_W-1:0];
        if (state_reg == S_RDA) begin
            rd_addr = edge_reg[VIDX_W-1:0] + VIDX_W'(1);
        end
    end

    always_comb begin
        vsel = sel_reg ? vb_reg : va_reg;
        cx   = 11'(signed'({2'b0, vsel[2*POS_W-1:POS_W]})) - 11'sd200;
        cy   = 11'(signed'({2'b0, vsel[POS_W-1:0]})) - 11'(PIVOT_Y_SCL);
        cyr  = 11'(signed'({2'b0, vsel[POS_W-1:0]})) - 11'(PIVOT_Y_ROT);
        rot_x = WIDE_W'(p_xc_reg) - WIDE_W'(p_ys_reg);
        rot_y = WIDE_W'(p_xs_reg) + WIDE_W'(p_yc_reg);
        // truncate toward zero
        rot_x = ((rot_x + (rot_x[WIDE_W-1] ? WIDE_W'(16383) : WIDE_W'(0))) >>> Q14_W)
                + WIDE_W'(PIVOT_X);
        rot_y = ((rot_y + (rot_y[WIDE_W-1] ? WIDE_W'(16383) : WIDE_W'(0))) >>> Q14_W)
                + WIDE_W'(PIVOT_Y_ROT);
        case (mode_reg)
            MODE_TRANSLATE: begin
                tx_w = WIDE_W'(vsel[2*POS_W-1:POS_W]) + WIDE_W'(cfg.shift_x);
                ty_w = WIDE_W'(vsel[POS_W-1:0]) - WIDE_W'(cfg.shift_y);
            end
            MODE_SCALE: begin
                tx_w = WIDE_W'(p_sx_reg) + WIDE_W'(PIVOT_X);
                ty_w = WIDE_W'(p_sy_reg) + WIDE_W'(PIVOT_Y_SCL);
            end
            MODE_ROTATE: begin
                tx_w = rot_x;
                ty_w = rot_y;
            end
            default: begin
                tx_w = WIDE_W'(vsel[2*POS_W-1:POS_W]);
                ty_w = WIDE_W'(vsel[POS_W-1:0]);
            end
        endcase
        tx = sat16(tx_w);
        ty = sat16(ty_w);
    end

    // a holds vertex e+1, b holds vertex e
    // live edges run newer to older, redraw edges run forward
    always_comb begin
        if (mode_reg == MODE_LIVE) begin
            sx0 = ta_x_reg; sy0 = ta_y_reg; sx1 = tb_x_reg; sy1 = tb_y_reg;
        end else begin
            sx0 = tb_x_reg; sy0 = tb_y_reg; sx1 = ta_x_reg; sy1 = ta_y_reg;
        end
        dx   = 17'(sx1) - 17'(sx0);
        dy   = 17'(sy1) - 17'(sy0);
        mx   = dx[16] ? 16'(-dx) : dx[15:0];
        my   = dy[16] ? 16'(-dy) : dy[15:0];
        span = (mx > my) ? mx : my;
    end

    always_comb begin
        ax_adj = acc_x_reg + (acc_x_reg[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));
        ay_adj = acc_y_reg + (acc_y_reg[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));
        px_w   = ax_adj >>> FRAC_BITS;
        py_w   = ay_adj >>> FRAC_BITS;
        px     = px_w[COORD_W-1:0];
        py     = py_w[COORD_W-1:0];
        in_img = (px >= 0) && (px < COORD_W'(IMAGE_SIZE)) &&
                 (py >= 0) && (py < COORD_W'(IMAGE_SIZE));
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (state_reg == S_IDLE && q_valid && open_reg && vcnt_reg < VCNT_W'(MAX_VERTICES)) begin
            if (q_item.kind == KIND_VERTEX) begin
                mem[vcnt_reg[VIDX_W-1:0]] <= {q_item.pos_x, q_item.pos_y};
            end else if (q_item.kind == KIND_CLOSE && vcnt_reg != '0) begin
                mem[vcnt_reg[VIDX_W-1:0]] <= {first_x_reg, first_y_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vcnt_reg     <= '0;
            edge_reg     <= '0;
            open_reg     <= 1'b1;
            mode_reg     <= MODE_LIVE;
            pend_clr_reg <= 1'b0;
            dropped_reg  <= 1'b0;
            left_reg     <= '0;
            m_tvalid     <= 1'b0;
            sel_reg      <= 1'b0;
        end else begin
            // the emit state sets the output valid itself
            if (m_tvalid && m_tready && state_reg != S_EMIT) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        case (q_item.kind)
                            KIND_VERTEX, KIND_CLOSE: begin
                                if (open_reg) begin
                                    if (q_item.kind == KIND_CLOSE) begin
                                        open_reg <= 1'b0;
                                    end
                                    if (q_item.kind == KIND_CLOSE && vcnt_reg == '0) begin
                                        open_reg <= 1'b0;
                                    end else if (vcnt_reg >= VCNT_W'(MAX_VERTICES)) begin
                                        dropped_reg <= 1'b1;
                                    end else begin
                                        if (vcnt_reg == '0) begin
                                            first_x_reg <= q_item.pos_x;
                                            first_y_reg <= q_item.pos_y;
                                        end
                                        vcnt_reg <= vcnt_reg + VCNT_W'(1);
                                    end
                                end
                            end
                            KIND_REDRAW: begin
                                mode_reg     <= q_item.mode;
                                edge_reg     <= '0;
                                left_reg     <= '0;
                                pend_clr_reg <= 1'b1;
                            end
                            KIND_TICK: begin
                                if (left_reg != '0) begin
                                    state_reg <= S_EMIT;
                                end else if (more_edges) begin
                                    state_reg <= S_RDA;
                                end else begin
                                    mode_reg <= MODE_LIVE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB: begin
                    va_reg    <= rd_data_reg;
                    state_reg <= S_CAPB;
                end
                S_CAPB: begin
                    vb_reg    <= rd_data_reg;
                    sel_reg   <= 1'b0;
                    edge_reg  <= edge_reg + VCNT_W'(1);
                    state_reg <= S_XM;
                end
                S_XM: begin
                    p_xc_reg  <= 27'(cx) * 27'(cfg.cos_q14);
                    p_ys_reg  <= 27'(cyr) * 27'(cfg.sin_q14);
                    p_xs_reg  <= 27'(cx) * 27'(cfg.sin_q14);
                    p_yc_reg  <= 27'(cyr) * 27'(cfg.cos_q14);
                    p_sx_reg  <= 19'(cx) * 19'(cfg.scale_x);
                    p_sy_reg  <= 19'(cy) * 19'(cfg.scale_y);
                    state_reg <= S_XS;
                end
                S_XS: begin
                    if (!sel_reg) begin
                        ta_x_reg  <= tx;
                        ta_y_reg  <= ty;
                        sel_reg   <= 1'b1;
                        state_reg <= S_XM;
                    end else begin
                        tb_x_reg  <= tx;
                        tb_y_reg  <= ty;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    acc_x_reg <= (ACC_W'(sx0) <<< FRAC_BITS) + ACC_W'(1 << (FRAC_BITS - 1));
                    acc_y_reg <= (ACC_W'(sy0) <<< FRAC_BITS) + ACC_W'(1 << (FRAC_BITS - 1));
                    span_reg  <= span;
                    neg_x_reg <= dx[16];
                    neg_y_reg <= dy[16];
                    rx_reg    <= 18'(mx);
                    ry_reg    <= 18'(my);
                    qx_reg    <= '0;
                    qy_reg    <= '0;
                    qcnt_reg  <= QCNT_W'(QUO_W - 1);
                    if (span == '0) begin
                        step_x_reg <= '0;
                        step_y_reg <= '0;
                        left_reg   <= 17'd1;
                        state_reg  <= S_EMIT;
                    end else begin
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle on each axis
                    if (rx_reg >= 18'(span_reg)) begin
                        rx_reg <= (rx_reg - 18'(span_reg)) << 1;
                        qx_reg <= {qx_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        rx_reg <= rx_reg << 1;
                        qx_reg <= {qx_reg[QUO_W-2:0], 1'b0};
                    end
                    if (ry_reg >= 18'(span_reg)) begin
                        ry_reg <= (ry_reg - 18'(span_reg)) << 1;
                        qy_reg <= {qy_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        ry_reg <= ry_reg << 1;
                        qy_reg <= {qy_reg[QUO_W-2:0], 1'b0};
                    end
                    qcnt_reg <= qcnt_reg - QCNT_W'(1);
                    if (qcnt_reg == '0) begin
                        state_reg <= S_EMIT;
                        left_reg  <= 17'(span_reg);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid      <= 1'b1;
                        m_pix_x       <= px;
                        m_pix_y       <= py;
                        m_in_image    <= in_img;
                        m_clear_first <= pend_clr_reg;
                        m_dropped     <= dropped_reg;
                        m_last        <= (left_reg == 17'd1) && !more_edges;
                        if ((left_reg == 17'd1) && !more_edges) begin
                            mode_reg <= MODE_LIVE;
                        end
                        pend_clr_reg  <= 1'b0;
                        acc_x_reg     <= acc_x_reg + ACC_W'(step_x_reg);
                        acc_y_reg     <= acc_y_reg + ACC_W'(step_y_reg);
                        left_reg      <= left_reg - 17'd1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // division finishing writes the signed steps
            if (state_reg == S_DIV && qcnt_reg == '0) begin
                step_x_reg <= neg_x_reg ? -STEP_W'({qx_reg[QUO_W-2:0], (rx_reg >= 18'(span_reg))})
                                        :  STEP_W'({qx_reg[QUO_W-2:0], (rx_reg >= 18'(span_reg))});
                step_y_reg <= neg_y_reg ? -STEP_W'({qy_reg[QUO_W-2:0], (ry_reg >= 18'(span_reg))})
                                        :  STEP_W'({qy_reg[QUO_W-2:0], (ry_reg >= 18'(span_reg))});
            end
        end
    end

endmodule

FILE: design/polygon_transform_dda_raster_core.sv
`timescale 1ns / 1ps
// vertex, close and redraw items retire as they leave the queue
// a tick inside a segment goes to the emit state, which registers its pixel once the output is free
// a tick that opens a segment passes through store reads, two transforms,
// and a 17-step divider producing both axis steps in parallel
// reset: aresetn synchronous, active low; clears queue, counters, flags and the
// output valid, loads register defaults; the vertex store is left uninitialized
module polygon_transform_dda_raster_core import ptdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pos_x[8:0], pos_y[17:9], zero fill
    input  logic [2:0]  s_tuser,   // func
    // pixel items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pix_x[15:0], pix_y[31:16], in_image[32],
                                   // clear_first[33], vertex_dropped[34], zero fill
    output logic        m_tlast    // last_of_draw
);

    cfg_t  cfg_reg;
    logic  q_valid, q_pop;
    item_t q_item;
    logic signed [COORD_W-1:0] pix_x, pix_y;
    logic  in_image, clear_first, dropped;

    // config writes are always taken, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shift_x <= '0;
            cfg_reg.shift_y <= '0;
            cfg_reg.scale_x <= 8'sd1;
            cfg_reg.scale_y <= 8'sd1;
            cfg_reg.cos_q14 <= 16'sd16384;
            cfg_reg.sin_q14 <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SHIFT_X: cfg_reg.shift_x <= cfg_data[9:0];
                REG_SHIFT_Y: cfg_reg.shift_y <= cfg_data[9:0];
                REG_SCALE_X: cfg_reg.scale_x <= cfg_data[7:0];
                REG_SCALE_Y: cfg_reg.scale_y <= cfg_data[7:0];
                REG_COS:     cfg_reg.cos_q14 <= cfg_data;
                REG_SIN:     cfg_reg.sin_q14 <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify into a two-item queue
    ptdr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .s_pos_x  (s_tdata[8:0]),
        .s_pos_y  (s_tdata[17:9]),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: polygon store, transforms, line setup and pixel stepping
    ptdr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_pix_x       (pix_x),
        .m_pix_y       (pix_y),
        .m_in_image    (in_image),
        .m_clear_first (clear_first),
        .m_last        (m_tlast),
        .m_dropped     (dropped)
    );

    assign m_tdata = {5'b0, dropped, clear_first, in_image, pix_y, pix_x};

    // output valid drops during reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // the dropped flag is sticky
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(m_tdata[34]) |-> m_tdata[34])
        else $error("dropped flag cleared");

endmodule
